// ===== rtl/xlb_pkg.sv =====
// ----------------------------------------------------------------------------
// xlb_pkg
// shared sizes, action codes and row store types for the xor basis engine
// ----------------------------------------------------------------------------
package xlb_pkg;

  // vector width kept by the basis (2 to 64)
  localparam int unsigned VECTOR_WIDTH = 64;
  localparam int unsigned IDX_W        = $clog2(VECTOR_WIDTH);
  localparam int unsigned PORT_W       = 64;
  localparam int unsigned RANK_W       = 7;
  localparam int unsigned ACT_W        = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CHECK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COMBINE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MAX     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

  typedef logic [VECTOR_WIDTH-1:0] vec_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // row write request
  typedef struct packed {
    logic en;
    idx_t addr;
    vec_t data;
  } row_wr_t;

  // registered row read response
  typedef struct packed {
    logic valid;
    vec_t data;
  } row_rd_t;

endpackage

// ===== rtl/xlb_row_store.sv =====
// ----------------------------------------------------------------------------
// xlb_row_store
// basis row memory with one valid flop per row; an empty row reads as zero
// ----------------------------------------------------------------------------
module xlb_row_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  xlb_pkg::row_wr_t wr_i,
  input  xlb_pkg::idx_t    rd_addr_i,
  output xlb_pkg::row_rd_t rd_o
);

  xlb_pkg::vec_t                      mem_q [xlb_pkg::VECTOR_WIDTH];
  logic [xlb_pkg::VECTOR_WIDTH-1:0]   valid_q;
  xlb_pkg::vec_t                      rd_data_q;
  logic                               rd_valid_q;

  // row memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // valid bits, cleared at once by reset or clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // empty rows read as zero
  assign rd_o.valid = rd_valid_q;
  assign rd_o.data  = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/xor_linear_basis_engine.sv =====
// ----------------------------------------------------------------------------
// xor_linear_basis_engine
// gf(2) linear basis of vectors with insert, check, combine, max and clear
// ----------------------------------------------------------------------------
// Usage: drive action_i and vector_i with start high; the command transfers
// at a rising edge where start is high and busy is low. Exactly one result
// per command appears on flag_o, word_o and rank_o, marked by done_o for one
// cycle; the receiver cannot stall, so it must take the result that cycle.
// Operation: insert, check, combine and max scan the basis rows from the top
// row down, one row per cycle through a single xor/compare step fed by the
// registered read port of the row memory. A scan covers up to VECTOR_WIDTH
// rows (64) and stops early when insert stores a row or check finds an
// empty row; done_o rises in the cycle after the last row is scanned and
// busy is already low then, so the next command can transfer while done_o
// is high. Clear and unknown actions answer from idle without a scan.
// Reset (rst_ni low, asynchronous) empties the basis at once through the
// per-row valid bits and sets the rank to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module xor_linear_basis_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [xlb_pkg::ACT_W-1:0]           action_i,
  input  logic [xlb_pkg::PORT_W-1:0]          vector_i,
  output logic                                busy,
  output logic                                done_o,
  output logic                                flag_o,
  output logic [xlb_pkg::PORT_W-1:0]          word_o,
  output logic [xlb_pkg::RANK_W-1:0]          rank_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam xlb_pkg::idx_t TOP_IDX = xlb_pkg::IDX_W'(xlb_pkg::VECTOR_WIDTH - 1);
  localparam xlb_pkg::vec_t ONE_VEC = xlb_pkg::VECTOR_WIDTH'(1);

  logic                          state_q, state_d;
  logic [xlb_pkg::ACT_W-1:0]     act_q, act_d;
  xlb_pkg::vec_t                 v_q, v_d;
  xlb_pkg::vec_t                 mask_q, mask_d;
  xlb_pkg::idx_t                 idx_q, idx_d;
  logic [xlb_pkg::RANK_W-1:0]    rank_q, rank_d;
  logic                          done_q, done_d;
  logic                          flag_q, flag_d;
  logic [xlb_pkg::PORT_W-1:0]    word_q, word_d;

  logic                          accept;
  logic                          clear;
  xlb_pkg::idx_t                 rd_addr;
  xlb_pkg::row_wr_t              wr;
  xlb_pkg::row_rd_t              rd;
  logic                          cur_bit;
  logic                          last;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_SCAN);
  assign last   = (idx_q == '0);

  // read the top row at command transfer, then the next row down each cycle
  assign rd_addr = (state_q == ST_IDLE) ? TOP_IDX : (last ? idx_q : idx_q - 1'b1);

  xlb_row_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  // sequencer and shared row step
  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    v_d     = v_q;
    mask_d  = mask_q;
    idx_d   = idx_q;
    rank_d  = rank_q;
    done_d  = 1'b0;
    flag_d  = flag_q;
    word_d  = word_q;
    clear   = 1'b0;
    wr.en   = 1'b0;
    wr.addr = idx_q;
    wr.data = v_q;
    cur_bit = v_q[idx_q];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d  = action_i;
          v_d    = (action_i == xlb_pkg::ACT_MAX) ? '0
                                                  : vector_i[xlb_pkg::VECTOR_WIDTH-1:0];
          mask_d = '0;
          idx_d  = TOP_IDX;
          if (action_i == xlb_pkg::ACT_INSERT || action_i == xlb_pkg::ACT_CHECK ||
              action_i == xlb_pkg::ACT_COMBINE || action_i == xlb_pkg::ACT_MAX) begin
            state_d = ST_SCAN;
          end else begin
            // clear and unknown actions answer at once
            if (action_i == xlb_pkg::ACT_CLEAR) begin
              clear  = 1'b1;
              rank_d = '0;
            end
            done_d = 1'b1;
            flag_d = 1'b0;
            word_d = '0;
          end
        end
      end

      ST_SCAN: begin
        case (act_q)
          xlb_pkg::ACT_INSERT: begin
            if (cur_bit && !rd.valid) begin
              wr.en   = 1'b1;
              rank_d  = rank_q + 1'b1;
              state_d = ST_IDLE;
              done_d  = 1'b1;
              flag_d  = 1'b1;
              word_d  = '0;
            end else begin
              if (cur_bit) begin
                v_d = v_q ^ rd.data;
              end
              if (last) begin
                state_d = ST_IDLE;
                done_d  = 1'b1;
                flag_d  = 1'b0;
                word_d  = '0;
              end
            end
          end

          xlb_pkg::ACT_CHECK: begin
            if (cur_bit && !rd.valid) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              flag_d  = 1'b0;
              word_d  = '0;
            end else begin
              if (cur_bit) begin
                v_d = v_q ^ rd.data;
              end
              if (last) begin
                state_d = ST_IDLE;
                done_d  = 1'b1;
                flag_d  = 1'b1;
                word_d  = '0;
              end
            end
          end

          xlb_pkg::ACT_COMBINE: begin
            if (cur_bit) begin
              v_d    = v_q ^ rd.data;
              mask_d = mask_q | (ONE_VEC << idx_q);
            end
            if (last) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              flag_d  = 1'b0;
              word_d  = xlb_pkg::PORT_W'(mask_d);
            end
          end

          xlb_pkg::ACT_MAX: begin
            // v_q serves as the running maximum here
            if (!cur_bit) begin
              v_d = v_q ^ rd.data;
            end
            if (last) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              flag_d  = 1'b0;
              word_d  = xlb_pkg::PORT_W'(v_d);
            end
          end

          default: begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
            flag_d  = 1'b0;
            word_d  = '0;
          end
        endcase

        if (!last) begin
          idx_d = idx_q - 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rank_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    v_q    <= v_d;
    mask_q <= mask_d;
    idx_q  <= idx_d;
    flag_q <= flag_d;
    word_q <= word_d;
  end

  assign done_o = done_q;
  assign flag_o = flag_q;
  assign word_o = word_q;
  assign rank_o = rank_q;

`ifndef SYNTHESIS
  // rank never exceeds the number of rows
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_q <= xlb_pkg::RANK_W'(xlb_pkg::VECTOR_WIDTH))
    else $error("rank above row count");

  // a result is only shown when the engine is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // the rank moves only together with a result
  a_rank_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rank_q) |-> done_o)
    else $error("rank changed without a result");

  // rows are written only during an insert scan
  a_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ST_SCAN && act_q == xlb_pkg::ACT_INSERT))
    else $error("row write outside insert scan");
`endif

endmodule
